// ----- design/insr_pkg.sv -----
// Shared constants and types for the Newton square root block.
package insr_pkg;

	localparam int RADICAND_BITS = 32;
	localparam int DIV_CNT_BITS = $clog2(RADICAND_BITS);
	localparam int ROUND_BITS = 8;
	localparam logic [ROUND_BITS-1:0] ROUND_COUNT_RESET = ROUND_BITS'(100);
	localparam logic [RADICAND_BITS-1:0] START_ESTIMATE = RADICAND_BITS'(1);

	typedef logic [RADICAND_BITS-1:0] word_t;

	typedef struct packed {
		logic  start;
		word_t dividend;
		word_t divisor;
	} div_req_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CHECK,
		ST_DIVIDE,
		ST_FINISH
	} insr_state_t;

endpackage

// ----- design/insr_div.sv -----
// Restoring divider: one quotient bit per cycle, dividend shifted out as quotient shifts in.
module insr_div
	import insr_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output logic     done,
	output word_t    quotient
);

	logic                    active_q;
	logic                    done_q;
	logic [DIV_CNT_BITS-1:0] cnt_q;
	word_t                   rem_q;
	word_t                   quo_q;
	word_t                   dsr_q;

	logic [RADICAND_BITS:0] trial;
	logic [RADICAND_BITS:0] diff;
	logic                   qbit;

	assign trial = {rem_q, quo_q[RADICAND_BITS-1]};
	assign diff  = trial - {1'b0, dsr_q};
	assign qbit  = ~diff[RADICAND_BITS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			done_q   <= 1'b0;
			cnt_q    <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start && !active_q) begin
				active_q <= 1'b1;
				cnt_q    <= DIV_CNT_BITS'(RADICAND_BITS - 1);
			end else if (active_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					active_q <= 1'b0;
					done_q   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start && !active_q) begin
			rem_q <= '0;
			quo_q <= req.dividend;
			dsr_q <= req.divisor;
		end else if (active_q) begin
			// remainder stays below the divisor, so it fits the word
			rem_q <= qbit ? diff[RADICAND_BITS-1:0] : trial[RADICAND_BITS-1:0];
			quo_q <= {quo_q[RADICAND_BITS-2:0], qbit};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

	a_start_runs: assert property (@(posedge clk) disable iff (!arst_n)
		req.start && !active_q |=> active_q && !done_q)
		else $error("divider did not start");
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !active_q)
		else $error("divider done while still active");
	a_done_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		active_q && cnt_q == '0 |=> done_q)
		else $error("divider missed its done pulse");

endmodule

// ----- design/integer_newton_square_root.sv -----
// Integer square root by the Newton recurrence, one round per serial division.
// Each round: the check state loads the divider, the restoring divider produces
// RADICAND_BITS quotient bits, and its done pulse updates the estimate.
// done follows the request after at most round_count rounds; the next request is taken in the
// cycle after done; a zero radicand stops after one round.
// The result is shown for one cycle with done; the receiver cannot stall it.
// Asynchronous active-low reset returns to idle with round_count = 100.
module integer_newton_square_root
	import insr_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  logic [RADICAND_BITS-1:0] radicand,
	output logic                  done,
	output logic [RADICAND_BITS-1:0] root,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [ROUND_BITS-1:0] cfg_data
);

	insr_state_t           state_q, state_d;
	logic [ROUND_BITS-1:0] round_count_q;
	logic [ROUND_BITS-1:0] rounds_left_q;
	word_t                 n_q;
	word_t                 x_q;

	div_req_t div_req;
	logic     div_done;
	word_t    div_quo;

	logic                   finished;
	logic [RADICAND_BITS:0] sum;

	assign finished = (rounds_left_q == '0) || (x_q == '0);
	// one extra bit keeps the carry of the estimate plus quotient
	assign sum = {1'b0, x_q} + {1'b0, div_quo};

	insr_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (div_req),
		.done     (div_done),
		.quotient (div_quo)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:   if (start) state_d = ST_CHECK;
			ST_CHECK:  state_d = finished ? ST_FINISH : ST_DIVIDE;
			ST_DIVIDE: if (div_done) state_d = ST_CHECK;
			ST_FINISH: state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		busy             = 1'b1;
		done             = 1'b0;
		cfg_ready        = 1'b0;
		div_req.start    = 1'b0;
		div_req.dividend = n_q;
		div_req.divisor  = x_q;
		unique case (state_q)
			ST_IDLE: begin
				busy      = 1'b0;
				cfg_ready = 1'b1;
			end
			ST_CHECK:  div_req.start = ~finished;
			ST_DIVIDE: ;
			ST_FINISH: done = 1'b1;
			default:   ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			round_count_q <= ROUND_COUNT_RESET;
			rounds_left_q <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) round_count_q <= cfg_data;
			if (state_q == ST_IDLE && start) rounds_left_q <= round_count_q;
			else if (state_q == ST_DIVIDE && div_done) rounds_left_q <= rounds_left_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			n_q <= radicand;
			x_q <= START_ESTIMATE;
		end else if (state_q == ST_DIVIDE && div_done) begin
			x_q <= sum[RADICAND_BITS:1];
		end
	end

	assign root = x_q;

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy && !done)
		else $error("request accepted but block not busy");
	a_done_frees: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !busy && !done)
		else $error("block still busy after result");
	a_round_counts: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIVIDE && div_done |=> rounds_left_q == $past(rounds_left_q) - 1'b1)
		else $error("round counter did not step");

endmodule
